FILE: rtl/core/tmcg_pkg.sv
// tmcg_pkg: shared constants and types for the text-mode character generator
// no dependencies; imported by tmcg_render and the top level
package tmcg_pkg;

  localparam int ACTIVE_LINES_DEF  = 480;
  localparam int ACTIVE_PIXELS_DEF = 640;
  localparam int PIXEL_BITS_DEF    = 16;
  localparam int FONT_DEPTH_DEF    = 2048;

  localparam int OUT_BITS = 16;

  localparam logic [2:0] OP_WRITE_CELL = 3'd0;
  localparam logic [2:0] OP_SET_CURSOR = 3'd1;
  localparam logic [2:0] OP_PUT_TEXT   = 3'd2;
  localparam logic [2:0] OP_PALETTE    = 3'd3;
  localparam logic [2:0] OP_FONT       = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;
  localparam logic [2:0] OP_RENDER     = 3'd6;

  localparam logic [7:0] CODE_SPACE   = 8'd32;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_RETURN  = 8'd13;
  localparam logic [7:0] FIRST_GLYPH  = 8'd32;
  localparam logic [7:0] COL_MAX      = 8'hff;

  // one cell entry: code, foreground, background
  typedef struct packed {
    logic [7:0] code;
    logic [7:0] fg;
    logic [7:0] bg;
  } cell_t;

  // render step handed to the pixel stage
  typedef struct packed {
    logic valid;
    logic blank;
    logic eol;
    logic eof;
  } rctl_t;

endpackage

FILE: rtl/core/text_mode_character_generator_core.sv
// text_mode_character_generator_core: top level, cell grid memory and op sequencer
// depends on tmcg_pkg and tmcg_render
//
// Commands arrive on the s_axis channel, one per transaction; only render
// commands (op 6) give a transaction on m_axis: eight pixels in tdata and
// end of line / end of frame in tuser.
// A render result passes through the cell read, the palette and font
// read, the colour select and the output register. A render holds s_axis
// until its result has been taken, so commands follow one another at one
// per cycle except after a render or a clear. Clear sweeps the grid one
// cell per cycle over all ACTIVE_LINES/8*ACTIVE_PIXELS/8 cells (4800 by
// default), with s_axis held off.
// After rst the same sweep runs to fill the grid with spaces in foreground
// 1 on background 0; s_axis_tready stays low meanwhile. Palette entry 1
// reads all ones until written. A stalled m_axis holds its result and
// keeps s_axis_tready low.
module text_mode_character_generator_core #(
  parameter int ACTIVE_LINES  = tmcg_pkg::ACTIVE_LINES_DEF,
  parameter int ACTIVE_PIXELS = tmcg_pkg::ACTIVE_PIXELS_DEF,
  parameter int PIXEL_BITS    = tmcg_pkg::PIXEL_BITS_DEF,
  parameter int FONT_DEPTH    = tmcg_pkg::FONT_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[2:0], row[10:3], col[18:11], code[26:19], fg[34:27], bg[42:35],
  // index[53:43], value[69:54], zero fill to 72
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_0[15:0] .. pixel_7[127:112]
  output logic [127:0] m_axis_tdata,
  // end_of_line[0], end_of_frame[1]
  output logic [1:0]   m_axis_tuser
);
  import tmcg_pkg::*;

  localparam int GRID_ROWS = ACTIVE_LINES / 8;
  localparam int GRID_COLS = ACTIVE_PIXELS / 8;
  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int CAW       = $clog2(CELLS + 1);
  localparam int LW        = $clog2(ACTIVE_LINES);
  localparam int GW        = $clog2(GRID_COLS + 1);
  localparam int FAW       = $clog2(FONT_DEPTH);

  logic [2:0]  op;
  logic [7:0]  row, col, code, fg, bg;
  logic [10:0] index;
  logic [15:0] value;
  assign op    = s_axis_tdata[2:0];
  assign row   = s_axis_tdata[10:3];
  assign col   = s_axis_tdata[18:11];
  assign code  = s_axis_tdata[26:19];
  assign fg    = s_axis_tdata[34:27];
  assign bg    = s_axis_tdata[42:35];
  assign index = s_axis_tdata[53:43];
  assign value = s_axis_tdata[69:54];

  cell_t cells [CELLS];
  cell_t cell_rd;

  logic           clearing;
  logic [CAW-1:0] clr_addr;
  logic [LW-1:0]  scan_line;
  logic [GW-1:0]  scan_column;
  logic [7:0]     cursor_row, cursor_column;
  logic           busy;
  logic           accept;

  assign s_axis_tready = !clearing && !busy;
  assign accept = s_axis_tvalid && s_axis_tready;

  // cell write decode
  logic        wr_en;
  logic [7:0]  wr_r, wr_c;
  logic [CAW-1:0] wr_addr, rd_addr;
  always_comb begin
    wr_en = 1'b0;
    wr_r  = row;
    wr_c  = col;
    if (accept && op == OP_WRITE_CELL) begin
      wr_en = 1'b1;
    end else if (accept && op == OP_PUT_TEXT && code != CODE_NEWLINE &&
                 code != CODE_RETURN) begin
      wr_en = 1'b1;
      wr_r  = cursor_row;
      wr_c  = cursor_column;
    end
    if (32'(wr_r) >= GRID_ROWS || 32'(wr_c) >= GRID_COLS) begin
      wr_en = 1'b0;
    end
    wr_addr = CAW'(32'(wr_r) * GRID_COLS + 32'(wr_c));
    rd_addr = CAW'(32'(scan_line >> 3) * GRID_COLS + 32'(scan_column));
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      cells[clr_addr] <= '{code: CODE_SPACE, fg: 8'd1, bg: 8'd0};
    end else if (wr_en) begin
      cells[wr_addr] <= '{code: code, fg: fg, bg: bg};
    end
    cell_rd <= cells[rd_addr];
  end

  // render bookkeeping
  logic   is_render, row_ok;
  rctl_t  start;
  logic [2:0] line_lsb;
  assign is_render = accept && op == OP_RENDER;
  assign row_ok = 32'(scan_line >> 3) < GRID_ROWS;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clr_addr      <= '0;
      scan_line     <= '0;
      scan_column   <= '0;
      cursor_row    <= '0;
      cursor_column <= '0;
      start         <= '0;
    end else begin
      start.valid <= 1'b0;
      if (clearing) begin
        if (32'(clr_addr) == CELLS - 1) begin
          clearing <= 1'b0;
          clr_addr <= '0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end else if (accept) begin
        case (op)
          OP_SET_CURSOR: begin
            cursor_row    <= row;
            cursor_column <= col;
          end
          OP_PUT_TEXT: begin
            if (code == CODE_NEWLINE) begin
              cursor_column <= '0;
              cursor_row <= (32'(cursor_row) + 1 < GRID_ROWS) ? cursor_row + 1'b1 : 8'd0;
            end else if (code != CODE_RETURN && cursor_column != COL_MAX) begin
              cursor_column <= cursor_column + 1'b1;
            end
          end
          OP_CLEAR: begin
            clearing <= 1'b1;
          end
          OP_RENDER: begin
            start.valid <= 1'b1;
            start.blank <= !row_ok;
            start.eol   <= 1'b0;
            start.eof   <= 1'b0;
            if (32'(scan_column) + 1 >= GRID_COLS) begin
              scan_column <= '0;
              start.eol   <= 1'b1;
              if (32'(scan_line) + 1 >= ACTIVE_LINES) begin
                scan_line <= '0;
                start.eof <= 1'b1;
              end else begin
                scan_line <= scan_line + 1'b1;
              end
            end else begin
              scan_column <= scan_column + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_render) begin
      line_lsb <= scan_line[2:0];
    end
  end

  logic [PIXEL_BITS-1:0] pal_data;
  logic [31:0]           val32;
  assign val32    = {16'd0, value};
  assign pal_data = val32[PIXEL_BITS-1:0];

  tmcg_render #(
    .PIXEL_BITS(PIXEL_BITS),
    .FONT_DEPTH(FONT_DEPTH)
  ) u_render (
    .clk       (clk),
    .rst       (rst),
    .cell_in   (cell_rd),
    .line_lsb  (line_lsb),
    .start     (start),
    .pal_we    (accept && op == OP_PALETTE),
    .pal_addr  (index[7:0]),
    .pal_data  (pal_data),
    .font_we   (accept && op == OP_FONT && 32'(index) < FONT_DEPTH),
    .font_addr (index[FAW-1:0]),
    .font_data (value[7:0]),
    .busy      (busy),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .pixels    (m_axis_tdata),
    .eol       (m_axis_tuser[0]),
    .eof       (m_axis_tuser[1])
  );

endmodule

FILE: rtl/core/tmcg_render.sv
// tmcg_render: palette and font lookup, pixel expansion and output register
// depends on tmcg_pkg; the cell read happens in the top level
module tmcg_render #(
  parameter int PIXEL_BITS = tmcg_pkg::PIXEL_BITS_DEF,
  parameter int FONT_DEPTH = tmcg_pkg::FONT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // cell read result, valid in the same cycle as start
  input  tmcg_pkg::cell_t               cell_in,
  input  logic [2:0]                    line_lsb,
  input  tmcg_pkg::rctl_t               start,
  // palette and font writes
  input  logic                          pal_we,
  input  logic [7:0]                    pal_addr,
  input  logic [PIXEL_BITS-1:0]         pal_data,
  input  logic                          font_we,
  input  logic [$clog2(FONT_DEPTH)-1:0] font_addr,
  input  logic [7:0]                    font_data,
  output logic                          busy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [8*tmcg_pkg::OUT_BITS-1:0] pixels,
  output logic                          eol,
  output logic                          eof
);
  import tmcg_pkg::*;

  localparam int FAW = $clog2(FONT_DEPTH);

  logic [PIXEL_BITS-1:0] palette [256];
  logic [7:0]            font [FONT_DEPTH];
  logic [255:0]          pal_written;

  rctl_t                 s1, s2;
  logic [PIXEL_BITS-1:0] fgc, bgc;
  logic                  fgw, bgw, fg1, bg1;
  logic [7:0]            bits;
  logic [7:0]            glyph;
  logic [7:0]            fg_addr;
  logic [10:0]           faddr, fa_q4, fa_q2, fa_q1;
  logic [OUT_BITS-1:0]   fg16, bg16;

  assign glyph = (cell_in.code < FIRST_GLYPH) ? 8'd0 : cell_in.code - FIRST_GLYPH;

  // blank rows read palette entry 0 through the foreground port
  assign fg_addr = start.blank ? 8'd0 : cell_in.fg;

  // font address wraps at the font depth; below 8x the depth if FONT_DEPTH >= 224
  always_comb begin
    faddr = {glyph, line_lsb};
    fa_q4 = (32'(faddr) >= 4 * FONT_DEPTH) ? 11'(32'(faddr) - 4 * FONT_DEPTH) : faddr;
    fa_q2 = (32'(fa_q4) >= 2 * FONT_DEPTH) ? 11'(32'(fa_q4) - 2 * FONT_DEPTH) : fa_q4;
    fa_q1 = (32'(fa_q2) >= FONT_DEPTH) ? 11'(32'(fa_q2) - FONT_DEPTH) : fa_q2;
  end

  // palette reset: entry 1 reads all ones until written, the rest zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_written <= '0;
    end else if (pal_we) begin
      pal_written[pal_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette[pal_addr] <= pal_data;
    end
    if (font_we) begin
      font[font_addr] <= font_data;
    end
  end

  // stage 1: cell arrives, read palette and font
  always_ff @(posedge clk) begin
    fgc  <= palette[fg_addr];
    bgc  <= palette[cell_in.bg];
    fgw  <= pal_written[fg_addr];
    bgw  <= pal_written[cell_in.bg];
    fg1  <= (fg_addr == 8'd1);
    bg1  <= (cell_in.bg == 8'd1);
    bits <= font[fa_q1[FAW-1:0]];
  end

  function automatic logic [OUT_BITS-1:0] pal_val(input logic [PIXEL_BITS-1:0] d,
                                                  input logic w, input logic one);
    logic [31:0] x;
    x = '0;
    if (w) begin
      x[PIXEL_BITS-1:0] = d;
    end else if (one) begin
      x[PIXEL_BITS-1:0] = '1;
    end
    return x[OUT_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      out_valid <= 1'b0;
    end else begin
      s1 <= start;
      s2 <= s1;
      if (s2.valid) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    fg16 = pal_val(fgc, fgw, fg1);
    bg16 = pal_val(bgc, bgw, bg1);
  end

  logic [OUT_BITS-1:0] fg_r, bg_r;
  logic [7:0] bits_r;
  always_ff @(posedge clk) begin
    if (s1.valid) begin
      fg_r   <= fg16;
      bg_r   <= bg16;
      bits_r <= bits;
    end
  end

  // stage 2 to output register
  always_ff @(posedge clk) begin
    if (s2.valid) begin
      for (int k = 0; k < 8; k++) begin
        if (s2.blank) begin
          pixels[k*OUT_BITS +: OUT_BITS] <= fg_r;
        end else begin
          pixels[k*OUT_BITS +: OUT_BITS] <= bits_r[7-k] ? bg_r : fg_r;
        end
      end
      eol <= s2.eol;
      eof <= s2.eof;
    end
  end

  assign busy = start.valid || s1.valid || s2.valid || out_valid;
endmodule
